>>> sv/householder_row_triangularizer_unit_macros.svh
// assertion macros for the householder row triangulariser rtl
// expects i_clk and i_rst_n in the scope of each use
`ifndef HOUSEHOLDER_ROW_TRIANGULARIZER_UNIT_MACROS_SVH
`define HOUSEHOLDER_ROW_TRIANGULARIZER_UNIT_MACROS_SVH

// same-cycle implication
`define HRT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HRT_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/hrt_pkg.sv
// shared types, codes and constants of the householder row triangulariser
// no dependencies
`default_nettype none

package hrt_pkg;

    localparam int MAX_ROWS_DEF = 16;
    localparam int MAX_COLS_DEF = 16;
    localparam int CFG_W        = 5;
    localparam int STEPS        = 32;   // root and divide iterations
    localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

    // request codes
    localparam logic [1:0] REQ_WRITE   = 2'd0;
    localparam logic [1:0] REQ_START   = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_UP_READ = 2'd3;

    // status codes
    localparam logic [1:0] ST_READ_OK   = 2'd0;
    localparam logic [1:0] ST_DONE      = 2'd1;
    localparam logic [1:0] ST_DONE_ZERO = 2'd2;

    // register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [3:0]         row;
        logic [3:0]         col;
        logic signed [31:0] value;
    } t_request;

    typedef struct packed {
        logic signed [31:0] read_data;
        logic [1:0]         status;
    } t_result;

    typedef enum logic [4:0] {
        DP_NOP,
        DP_WR_IN,
        DP_RD_ELEM,
        DP_RD_UP,
        DP_RUN_CLR,
        DP_ACC_CLR,
        DP_RD,
        DP_NORM_MUL,
        DP_NORM_ACC,
        DP_ZERO_PIV,
        DP_SQRT_INIT,
        DP_SQRT_STEP,
        DP_CL,
        DP_E,
        DP_DOT_MUL,
        DP_DOT_ACC,
        DP_DIV_INIT,
        DP_DIV_STEP,
        DP_F,
        DP_UPD_MUL,
        DP_UPD_WR,
        DP_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   first;  // column is the pivot column
        logic   oor;    // request index out of range
    } t_dp_cmd;

    typedef struct packed {
        logic acc_zero;
        logic e_zero;
        logic d_zero;
    } t_dp_status;

endpackage

`default_nettype wire

>>> sv/hrt_ctrl.sv
// sequencer of the householder row triangulariser: request decode, config
// registers, pivot, row and column counters; uses hrt_pkg
`default_nettype none

`include "householder_row_triangularizer_unit_macros.svh"

module hrt_ctrl #(
    parameter int MAX_ROWS = hrt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = hrt_pkg::MAX_COLS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_start,
    input  wire hrt_pkg::t_request          i_req,
    input  wire                             i_cfg_we,
    input  wire                             i_cfg_idx,
    input  wire [hrt_pkg::CFG_W-1:0]        i_cfg_data,
    input  wire hrt_pkg::t_dp_status        i_status,
    output logic                            o_busy,
    output hrt_pkg::t_dp_cmd                o_cmd,
    output logic [$clog2(MAX_ROWS)-1:0]     o_row,
    output logic [$clog2(MAX_COLS)-1:0]     o_col
);

    localparam int RW   = $clog2(MAX_ROWS);
    localparam int CW   = $clog2(MAX_COLS);
    localparam int DMAX = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
    localparam int DIMW = ($clog2(DMAX + 1) > hrt_pkg::CFG_W) ?
                          $clog2(DMAX + 1) : hrt_pkg::CFG_W;
    localparam int NW   = $clog2(hrt_pkg::STEPS);

    typedef enum logic [20:0] {
        S_IDLE = 21'b1 << 0,
        S_PIV  = 21'b1 << 1,
        S_NRD  = 21'b1 << 2,
        S_NMUL = 21'b1 << 3,
        S_NACC = 21'b1 << 4,
        S_NCHK = 21'b1 << 5,
        S_SQRT = 21'b1 << 6,
        S_CL   = 21'b1 << 7,
        S_E    = 21'b1 << 8,
        S_ECHK = 21'b1 << 9,
        S_ROW  = 21'b1 << 10,
        S_DRD  = 21'b1 << 11,
        S_DMUL = 21'b1 << 12,
        S_DACC = 21'b1 << 13,
        S_DCHK = 21'b1 << 14,
        S_DIV  = 21'b1 << 15,
        S_F    = 21'b1 << 16,
        S_URD  = 21'b1 << 17,
        S_UMUL = 21'b1 << 18,
        S_UWR  = 21'b1 << 19,
        S_DONE = 21'b1 << 20
    } t_state;

    t_state r_state, n_state;
    logic [DIMW-1:0] r_p, n_p, r_r, n_r, r_k, n_k;
    logic [NW-1:0]   r_n, n_n;
    logic [hrt_pkg::CFG_W-1:0] r_rows, r_cols;

    logic [DIMW-1:0] rows_eff, cols_eff, npiv;
    logic            accept, row_ok, col_ok, last_col, last_row, last_piv, last_step;

    always_comb begin
        if (r_rows == '0) begin
            rows_eff = DIMW'(1);
        end else if (DIMW'(r_rows) > DIMW'(MAX_ROWS)) begin
            rows_eff = DIMW'(MAX_ROWS);
        end else begin
            rows_eff = DIMW'(r_rows);
        end
        if (r_cols == '0) begin
            cols_eff = DIMW'(1);
        end else if (DIMW'(r_cols) > DIMW'(MAX_COLS)) begin
            cols_eff = DIMW'(MAX_COLS);
        end else begin
            cols_eff = DIMW'(r_cols);
        end
    end

    assign npiv      = (rows_eff < cols_eff) ? rows_eff : cols_eff;
    assign accept    = i_start && (r_state == S_IDLE);
    assign row_ok    = DIMW'(i_req.row) < DIMW'(MAX_ROWS);
    assign col_ok    = DIMW'(i_req.col) < DIMW'(MAX_COLS);
    assign last_col  = (r_k + DIMW'(1)) == cols_eff;
    assign last_row  = (r_r + DIMW'(1)) == rows_eff;
    assign last_piv  = (r_p + DIMW'(1)) == npiv;
    assign last_step = r_n == NW'(hrt_pkg::STEPS - 1);
    assign o_busy    = r_state != S_IDLE;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= hrt_pkg::CFG_W'(16);
            r_cols <= hrt_pkg::CFG_W'(16);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == hrt_pkg::CFG_ROWS) begin
                r_rows <= i_cfg_data;
            end else begin
                r_cols <= i_cfg_data;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_r     = r_r;
        n_k     = r_k;
        n_n     = r_n;
        o_cmd.op    = hrt_pkg::DP_NOP;
        o_cmd.first = r_k == r_p;
        o_cmd.oor   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_req.req_type)
                        hrt_pkg::REQ_WRITE: begin
                            o_cmd.op = (row_ok && col_ok) ? hrt_pkg::DP_WR_IN
                                                          : hrt_pkg::DP_NOP;
                        end
                        hrt_pkg::REQ_START: begin
                            o_cmd.op = hrt_pkg::DP_RUN_CLR;
                            n_p      = '0;
                            n_state  = S_PIV;
                        end
                        hrt_pkg::REQ_READ: begin
                            o_cmd.op  = hrt_pkg::DP_RD_ELEM;
                            o_cmd.oor = !(row_ok && col_ok);
                        end
                        default: begin
                            o_cmd.op  = hrt_pkg::DP_RD_UP;
                            o_cmd.oor = !row_ok;
                        end
                    endcase
                end
            end
            S_PIV: begin
                o_cmd.op = hrt_pkg::DP_ACC_CLR;
                n_k      = r_p;
                n_state  = S_NRD;
            end
            S_NRD: begin
                o_cmd.op = hrt_pkg::DP_RD;
                n_state  = S_NMUL;
            end
            S_NMUL: begin
                o_cmd.op = hrt_pkg::DP_NORM_MUL;
                n_state  = S_NACC;
            end
            S_NACC: begin
                o_cmd.op = hrt_pkg::DP_NORM_ACC;
                if (last_col) begin
                    n_state = S_NCHK;
                end else begin
                    n_k     = r_k + DIMW'(1);
                    n_state = S_NRD;
                end
            end
            S_NCHK: begin
                if (i_status.acc_zero) begin
                    o_cmd.op = hrt_pkg::DP_ZERO_PIV;
                    n_p      = r_p + DIMW'(1);
                    n_state  = last_piv ? S_DONE : S_PIV;
                end else begin
                    o_cmd.op = hrt_pkg::DP_SQRT_INIT;
                    n_n      = '0;
                    n_state  = S_SQRT;
                end
            end
            S_SQRT: begin
                o_cmd.op = hrt_pkg::DP_SQRT_STEP;
                n_n      = r_n + NW'(1);
                if (last_step) begin
                    n_state = S_CL;
                end
            end
            S_CL: begin
                o_cmd.op = hrt_pkg::DP_CL;
                n_state  = S_E;
            end
            S_E: begin
                o_cmd.op = hrt_pkg::DP_E;
                n_state  = S_ECHK;
            end
            S_ECHK: begin
                if (i_status.e_zero || ((r_p + DIMW'(1)) >= rows_eff)) begin
                    n_p     = r_p + DIMW'(1);
                    n_state = last_piv ? S_DONE : S_PIV;
                end else begin
                    n_r     = r_p + DIMW'(1);
                    n_state = S_ROW;
                end
            end
            S_ROW: begin
                o_cmd.op = hrt_pkg::DP_ACC_CLR;
                n_k      = r_p;
                n_state  = S_DRD;
            end
            S_DRD: begin
                o_cmd.op = hrt_pkg::DP_RD;
                n_state  = S_DMUL;
            end
            S_DMUL: begin
                o_cmd.op = hrt_pkg::DP_DOT_MUL;
                n_state  = S_DACC;
            end
            S_DACC: begin
                o_cmd.op = hrt_pkg::DP_DOT_ACC;
                if (last_col) begin
                    n_state = S_DCHK;
                end else begin
                    n_k     = r_k + DIMW'(1);
                    n_state = S_DRD;
                end
            end
            S_DCHK: begin
                if (i_status.d_zero) begin
                    if (last_row) begin
                        n_p     = r_p + DIMW'(1);
                        n_state = last_piv ? S_DONE : S_PIV;
                    end else begin
                        n_r     = r_r + DIMW'(1);
                        n_state = S_ROW;
                    end
                end else begin
                    o_cmd.op = hrt_pkg::DP_DIV_INIT;
                    n_n      = '0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = hrt_pkg::DP_DIV_STEP;
                n_n      = r_n + NW'(1);
                if (last_step) begin
                    n_state = S_F;
                end
            end
            S_F: begin
                o_cmd.op = hrt_pkg::DP_F;
                n_k      = r_p;
                n_state  = S_URD;
            end
            S_URD: begin
                o_cmd.op = hrt_pkg::DP_RD;
                n_state  = S_UMUL;
            end
            S_UMUL: begin
                o_cmd.op = hrt_pkg::DP_UPD_MUL;
                n_state  = S_UWR;
            end
            S_UWR: begin
                o_cmd.op = hrt_pkg::DP_UPD_WR;
                if (!last_col) begin
                    n_k     = r_k + DIMW'(1);
                    n_state = S_URD;
                end else if (last_row) begin
                    n_p     = r_p + DIMW'(1);
                    n_state = last_piv ? S_DONE : S_PIV;
                end else begin
                    n_r     = r_r + DIMW'(1);
                    n_state = S_ROW;
                end
            end
            S_DONE: begin
                o_cmd.op = hrt_pkg::DP_DONE;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // element row: request row while idle, working row in S_DRD, S_URD and S_UWR, pivot row otherwise
    always_comb begin
        if (r_state == S_IDLE) begin
            o_row = RW'(i_req.row);
            o_col = CW'(i_req.col);
        end else begin
            o_row = (r_state == S_DRD || r_state == S_URD || r_state == S_UWR) ?
                    RW'(r_r) : RW'(r_p);
            o_col = (r_state == S_CL) ? CW'(r_p) : CW'(r_k);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_p     <= '0;
            r_r     <= '0;
            r_k     <= '0;
            r_n     <= '0;
        end else begin
            r_state <= n_state;
            r_p     <= n_p;
            r_r     <= n_r;
            r_k     <= n_k;
            r_n     <= n_n;
        end
    end

    `HRT_ASSERT_NXT(a_start_busy, accept && i_req.req_type == hrt_pkg::REQ_START,
        o_busy, "start beat did not make the block busy")
    `HRT_ASSERT_NXT(a_access_idle, accept && i_req.req_type != hrt_pkg::REQ_START,
        !o_busy, "element access beat made the block busy")
    `HRT_ASSERT_IMP(a_col_range, r_state == S_NRD || r_state == S_DRD || r_state == S_URD,
        r_k < DIMW'(MAX_COLS), "column counter ran past the matrix")
    `HRT_ASSERT_IMP(a_row_range, r_state == S_DRD || r_state == S_URD || r_state == S_UWR,
        r_r < DIMW'(MAX_ROWS) && r_r > r_p, "working row outside the trailing rows")

endmodule

`default_nettype wire

>>> sv/hrt_datapath.sv
// datapath of the householder row triangulariser: element store, pivot row
// buffer, up store, square, root, divide and update arithmetic; uses hrt_pkg
`default_nettype none

module hrt_datapath #(
    parameter int MAX_ROWS = hrt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = hrt_pkg::MAX_COLS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire hrt_pkg::t_dp_cmd           i_cmd,
    input  wire [$clog2(MAX_ROWS)-1:0]      i_row,
    input  wire [$clog2(MAX_COLS)-1:0]      i_col,
    input  wire signed [31:0]               i_value,
    output hrt_pkg::t_dp_status             o_status,
    output logic                            o_res_valid,
    output hrt_pkg::t_result                o_res
);

    localparam int AW = $clog2(MAX_ROWS * MAX_COLS);

    typedef enum logic [1:0] {
        OUT_ELEM,
        OUT_UP,
        OUT_DONE
    } t_out_sel;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            sat32 = 32'sh7FFF_FFFF;
        end else if (x < -64'sd2147483648) begin
            sat32 = 32'sh8000_0000;
        end else begin
            sat32 = x[31:0];
        end
    endfunction

    logic [31:0] r_mem [MAX_ROWS * MAX_COLS];
    logic [31:0] r_buf [MAX_COLS];
    logic [31:0] r_ups [MAX_ROWS];
    logic [31:0] r_mem_q, r_buf_q, r_ups_q;

    logic signed [31:0] r_v, r_cl, r_up, r_f;
    logic [63:0]        r_prod_u, r_acc, r_x, r_res, r_bit, r_rem;
    logic signed [63:0] r_prod_s, r_d, r_e;
    logic [31:0]        r_q;
    logic               r_qsat, r_zflag, r_ov, r_ozero;
    t_out_sel           r_osel;

    hrt_pkg::t_dp_op    op;
    logic [AW-1:0]      addr;
    logic               mem_we, mem_re;
    logic [31:0]        mem_wdata;

    logic signed [31:0] mem_q_s, mop, mul_a, qv;
    logic [31:0]        mag, norm;
    logic [64:0]        norm_sum;
    logic [63:0]        trial, dmag, emag, rem2;
    logic signed [32:0] cl33;
    logic signed [63:0] up64, shifted, upd_sum;
    logic               div_big;

    assign op      = i_cmd.op;
    assign addr    = AW'(i_row) * AW'(MAX_COLS) + AW'(i_col);
    assign mem_q_s = r_mem_q;

    assign mag      = r_mem_q[31] ? (32'd0 - r_mem_q) : r_mem_q;
    assign norm_sum = {1'b0, r_acc} + {1'b0, r_prod_u};
    assign trial    = r_res + r_bit;
    assign norm     = r_acc[62] ? hrt_pkg::POS_MAX : r_res[31:0];
    assign cl33     = (r_v > 32'sd0) ? -$signed({1'b0, norm}) : $signed({1'b0, norm});
    assign up64     = {{32{r_v[31]}}, r_v} - {{31{cl33[32]}}, cl33};
    assign dmag     = r_d[63] ? (64'd0 - r_d) : r_d;
    assign emag     = r_e[63] ? (64'd0 - r_e) : r_e;
    assign div_big  = (dmag >= emag) || ({dmag[62:0], 1'b0} >= emag);
    assign rem2     = {r_rem[62:0], 1'b0};
    assign qv       = (r_qsat || r_q > hrt_pkg::POS_MAX) ? hrt_pkg::POS_MAX : r_q;
    assign mop      = i_cmd.first ? r_up : $signed(r_buf_q);
    assign mul_a    = (op == hrt_pkg::DP_UPD_MUL) ? r_f : mem_q_s;
    assign shifted  = r_prod_s >>> 16;
    assign upd_sum  = {{32{r_mem_q[31]}}, r_mem_q} + shifted;

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = i_value;
        unique case (op)
            hrt_pkg::DP_WR_IN: begin
                mem_we = 1'b1;
            end
            hrt_pkg::DP_CL: begin
                mem_we    = 1'b1;
                mem_wdata = cl33[31:0];
            end
            hrt_pkg::DP_UPD_WR: begin
                mem_we    = 1'b1;
                mem_wdata = sat32(upd_sum);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign mem_re = (op == hrt_pkg::DP_RD) || (op == hrt_pkg::DP_RD_ELEM && !i_cmd.oor);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[addr] <= mem_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == hrt_pkg::DP_NORM_MUL) begin
            r_buf[i_col] <= r_mem_q;
        end
        if (op == hrt_pkg::DP_RD) begin
            r_buf_q <= r_buf[i_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == hrt_pkg::DP_CL) begin
            r_ups[i_row] <= sat32(up64);
        end else if (op == hrt_pkg::DP_ZERO_PIV) begin
            r_ups[i_row] <= '0;
        end
        if (op == hrt_pkg::DP_RD_UP && !i_cmd.oor) begin
            r_ups_q <= r_ups[i_row];
        end
    end

    always_ff @(posedge i_clk) begin
        case (op)
            hrt_pkg::DP_RUN_CLR, hrt_pkg::DP_ACC_CLR: begin
                r_acc <= '0;
                r_d   <= '0;
            end
            hrt_pkg::DP_NORM_MUL: begin
                r_prod_u <= mag * mag;
                if (i_cmd.first) begin
                    r_v <= mem_q_s;
                end
            end
            hrt_pkg::DP_NORM_ACC: begin
                r_acc <= (norm_sum[64:62] != 3'b000) ? (64'd1 << 62) : norm_sum[63:0];
            end
            hrt_pkg::DP_SQRT_INIT: begin
                r_x   <= r_acc;
                r_res <= '0;
                r_bit <= 64'd1 << 62;
            end
            hrt_pkg::DP_SQRT_STEP: begin
                if (r_x >= trial) begin
                    r_x   <= r_x - trial;
                    r_res <= (r_res >> 1) + r_bit;
                end else begin
                    r_res <= r_res >> 1;
                end
                r_bit <= r_bit >> 2;
            end
            hrt_pkg::DP_CL: begin
                r_cl <= cl33[31:0];
                r_up <= sat32(up64);
            end
            hrt_pkg::DP_E: begin
                r_e <= r_up * r_cl;
            end
            hrt_pkg::DP_DOT_MUL, hrt_pkg::DP_UPD_MUL: begin
                r_prod_s <= mul_a * mop;
            end
            hrt_pkg::DP_DOT_ACC: begin
                r_d <= r_d + shifted;
            end
            hrt_pkg::DP_DIV_INIT: begin
                r_qsat <= div_big;
                r_rem  <= dmag;
                r_q    <= '0;
            end
            hrt_pkg::DP_DIV_STEP: begin
                if (rem2 >= emag) begin
                    r_rem <= rem2 - emag;
                    r_q   <= {r_q[30:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[30:0], 1'b0};
                end
            end
            hrt_pkg::DP_F: begin
                r_f <= (r_d[63] ^ r_e[63]) ? -qv : qv;
            end
            default: begin
            end
        endcase
    end

    // result beat register and zero pivot flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov    <= 1'b0;
            r_zflag <= 1'b0;
        end else begin
            r_ov <= (op == hrt_pkg::DP_RD_ELEM) || (op == hrt_pkg::DP_RD_UP) ||
                    (op == hrt_pkg::DP_DONE);
            if (op == hrt_pkg::DP_RUN_CLR) begin
                r_zflag <= 1'b0;
            end else if (op == hrt_pkg::DP_ZERO_PIV) begin
                r_zflag <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (op == hrt_pkg::DP_RD_ELEM) begin
            r_osel  <= OUT_ELEM;
            r_ozero <= i_cmd.oor;
        end else if (op == hrt_pkg::DP_RD_UP) begin
            r_osel  <= OUT_UP;
            r_ozero <= i_cmd.oor;
        end else if (op == hrt_pkg::DP_DONE) begin
            r_osel  <= OUT_DONE;
            r_ozero <= 1'b1;
        end
    end

    always_comb begin
        o_res_valid = r_ov;
        if (r_ozero) begin
            o_res.read_data = '0;
        end else if (r_osel == OUT_UP) begin
            o_res.read_data = r_ups_q;
        end else begin
            o_res.read_data = r_mem_q;
        end
        if (r_osel == OUT_DONE) begin
            o_res.status = r_zflag ? hrt_pkg::ST_DONE_ZERO : hrt_pkg::ST_DONE;
        end else begin
            o_res.status = hrt_pkg::ST_READ_OK;
        end
    end

    assign o_status.acc_zero = r_acc == '0;
    assign o_status.e_zero   = r_e == '0;
    assign o_status.d_zero   = r_d == '0;

endmodule

`default_nettype wire

>>> sv/householder_row_triangularizer_unit.sv
// top level of the householder row triangulariser
// instantiates hrt_ctrl and hrt_datapath; uses hrt_pkg
`default_nettype none

// usage
//   request channel: a beat is taken at a rising edge with i_start high and
//   o_busy low. element writes give no result; element and up reads give a
//   result beat on the cycle after they are taken, and may be issued every
//   cycle
//   a start beat raises o_busy for the whole reduction. per pivot p over the
//   cols - p columns from p on: the norm, the root, the reflector, then per
//   trailing row the dot product and, when it is non zero, the divide and the
//   update; a zero pivot row costs the norm only. the single port element
//   store handles each element in turn, and the root and divide give one bit
//   per cycle. the done beat (read data zero, status 1 or 2) follows the last
//   pivot. result beats: o_res_valid is high for exactly one cycle; the
//   receiver cannot hold them off. config: i_cfg_we writes rows (index 0) or
//   cols (index 1); the user must write only while idle, the block does not
//   enforce it. reset (synchronous, active low) returns to idle, sizes to 16
//   by 16 and drops any result beat; the element and up stores keep their
//   contents
module householder_row_triangularizer_unit #(
    parameter int MAX_ROWS = hrt_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = hrt_pkg::MAX_COLS_DEF
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    output logic                        o_busy,
    input  wire hrt_pkg::t_request      i_req,
    output logic                        o_res_valid,
    output hrt_pkg::t_result            o_res,
    input  wire                         i_cfg_we,
    input  wire                         i_cfg_idx,
    input  wire [hrt_pkg::CFG_W-1:0]    i_cfg_data
);

    // command and status between sequencer and datapath
    hrt_pkg::t_dp_cmd               cmd;
    hrt_pkg::t_dp_status            status;
    logic [$clog2(MAX_ROWS)-1:0]    row;
    logic [$clog2(MAX_COLS)-1:0]    col;

    hrt_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_start),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_status   (status),
        .o_busy     (o_busy),
        .o_cmd      (cmd),
        .o_row      (row),
        .o_col      (col)
    );

    // value only matters for element writes, taken straight from the beat
    hrt_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_row       (row),
        .i_col       (col),
        .i_value     (i_req.value),
        .o_status    (status),
        .o_res_valid (o_res_valid),
        .o_res       (o_res)
    );

endmodule

`default_nettype wire
